// ===== rtl/ntw_pkg.sv =====
// ----------------------------------------------------------------------------
// ntw_pkg - shared types and constants for number_to_word_tokens
// Token kinds, sequencer step codes, controller/datapath command and status
// structs, and the table of scale word keys.
// ----------------------------------------------------------------------------
package ntw_pkg;

  localparam int NUM_W    = 64;               // input number width
  localparam int KEY_W    = 60;               // word key width
  localparam int KIND_W   = 2;                // token kind width
  localparam int GROUPS   = 7;                // three-digit groups, 10^0 .. 10^18
  localparam int GRP_W    = 3;
  localparam int DIGITS   = 3 * GROUPS;       // BCD digits held (top one stays 0)
  localparam int BCD_W    = 4 * DIGITS;
  localparam int CNT_W    = 6;                // conversion bit counter
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(NUM_W - 1);

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_WORD    = 2'd0;
  localparam kind_t KIND_SPACE   = 2'd1;
  localparam kind_t KIND_HYPHEN  = 2'd2;
  localparam kind_t KIND_NEWLINE = 2'd3;

  typedef logic [3:0] step_t;
  localparam step_t STEP_SEP     = 4'd0;   // space between spoken groups
  localparam step_t STEP_HUND    = 4'd1;   // hundreds digit word
  localparam step_t STEP_SP1     = 4'd2;   // space before "hundred"
  localparam step_t STEP_W100    = 4'd3;   // word 100
  localparam step_t STEP_SP2     = 4'd4;   // space after "hundred"
  localparam step_t STEP_TENS    = 4'd5;   // remainder word or tens word
  localparam step_t STEP_HYPH    = 4'd6;   // hyphen
  localparam step_t STEP_ONES    = 4'd7;   // ones word after hyphen
  localparam step_t STEP_SPS     = 4'd8;   // space before scale word
  localparam step_t STEP_SCALE   = 4'd9;   // scale word
  localparam step_t STEP_ZERO    = 4'd10;  // word 0 for a zero input
  localparam step_t STEP_NEWLINE = 4'd11;  // closing newline

  typedef struct packed {
    logic             load;   // capture a new number, clear BCD
    logic             shift;  // one double-dabble iteration
    logic             emit;   // load the output register with a token
    step_t            step;
    logic [GRP_W-1:0] grp;
  } cmd_t;

  typedef struct packed {
    logic [GROUPS-1:0] grp_nz;   // per group: nonzero
    logic              h_nz;     // current group: hundreds digit nonzero
    logic              rest_nz;  // current group: value below 100 nonzero
    logic              t_ge2;    // current group: tens digit at least 2
    logic              o_nz;     // current group: ones digit nonzero
    logic              out_busy; // output register full and not taken
  } sts_t;

  function automatic logic [KEY_W-1:0] scale_key(input logic [GRP_W-1:0] g);
    logic [KEY_W-1:0] k;
    unique case (g)
      3'd0:    k = 60'd1;
      3'd1:    k = 60'd1000;
      3'd2:    k = 60'd1000000;
      3'd3:    k = 60'd1000000000;
      3'd4:    k = 60'd1000000000000;
      3'd5:    k = 60'd1000000000000000;
      3'd6:    k = 60'd1000000000000000000;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/ntw_num_if.sv =====
// ----------------------------------------------------------------------------
// ntw_num_if - number request channel
// Valid/ready channel carrying one 64-bit unsigned number per request.
// ----------------------------------------------------------------------------
interface ntw_num_if;
  logic                       valid;
  logic                       ready;
  logic [ntw_pkg::NUM_W-1:0]  number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// ===== rtl/ntw_tok_if.sv =====
// ----------------------------------------------------------------------------
// ntw_tok_if - word token channel
// Valid/ready channel carrying one token (kind, word key, last) per request.
// ----------------------------------------------------------------------------
interface ntw_tok_if;
  logic                       valid;
  logic                       ready;
  logic [ntw_pkg::KIND_W-1:0] kind;
  logic [ntw_pkg::KEY_W-1:0]  word_key;
  logic                       last;

  modport source (output valid, output kind, output word_key, output last, input ready);
  modport sink   (input valid, input kind, input word_key, input last, output ready);
endinterface

// ===== rtl/number_to_word_tokens.sv =====
// ----------------------------------------------------------------------------
// number_to_word_tokens - spell a 64-bit number as English word tokens
// Converts the number to BCD, then emits words, spaces, hyphens and a closing
// newline, one token per request on the output channel.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                          | requests
//   --------+-----+----------------------------------+-------------------------
//   num     | in  | number[63:0]                     | one per run
//   tok     | out | kind[1:0], word_key[59:0], last  | 2 to 62 per run
//
// Sequence: a number is accepted, then converted (the double-dabble converter
// shifts one bit per cycle), then the top group is picked, then tokens are
// emitted one per free output slot, with an extra step for each spoken group
// without hundreds.
// Reset: clears the sequencer and the output valid flag; no memory to clear.
// Stalls: while tok.ready is low the output register holds its token and the
// sequencer waits; a new number is taken while the final newline still waits.
//
module number_to_word_tokens (
  input  logic         clk,
  input  logic         rst,
  ntw_num_if.sink      num,
  ntw_tok_if.source    tok
);

  ntw_pkg::cmd_t cmd;
  ntw_pkg::sts_t sts;

  // Controller: counts conversion shifts, then sequences groups and tokens.
  ntw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num.valid),
    .in_ready (num.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: binary to BCD, digit selection of the current group, and the
  // output register that parts the sequencer from the token consumer.
  ntw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .number    (num.number),
    .out_valid (tok.valid),
    .out_ready (tok.ready),
    .kind      (tok.kind),
    .word_key  (tok.word_key),
    .last      (tok.last)
  );

`ifndef NO_ASSERTIONS
  // Drop ready right after taking a number: one run at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    num.valid && num.ready |=> !num.ready)
    else $error("number accepted while a run is in progress");

  // Hold off new numbers while any token other than the final one is pending.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    tok.valid && !tok.last |-> !num.ready)
    else $error("input ready while a run still has tokens to send");

  // Only the newline carries last, and it carries key zero.
  a_last_is_newline: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.last |-> tok.kind == ntw_pkg::KIND_NEWLINE && tok.word_key == '0)
    else $error("last flag on a token other than the newline");
`endif

endmodule

// ===== rtl/ntw_datapath.sv =====
// ----------------------------------------------------------------------------
// ntw_datapath - binary to BCD converter and token output register
// Double-dabble one bit per shift command, group digit selection, token
// formation and the output register.
// ----------------------------------------------------------------------------
module ntw_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  ntw_pkg::cmd_t              cmd,
  output ntw_pkg::sts_t              sts,
  input  logic [ntw_pkg::NUM_W-1:0]  number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ntw_pkg::KIND_W-1:0] kind,
  output logic [ntw_pkg::KEY_W-1:0]  word_key,
  output logic                       last
);

  logic [ntw_pkg::NUM_W-1:0] bin;
  logic [ntw_pkg::BCD_W-1:0] bcd;
  logic [ntw_pkg::BCD_W-1:0] bcd_adj;
  logic [3:0]                gh [ntw_pkg::GROUPS];
  logic [3:0]                gt [ntw_pkg::GROUPS];
  logic [3:0]                go [ntw_pkg::GROUPS];
  logic [ntw_pkg::GROUPS-1:0] grp_nz;
  logic [3:0]                h, t, o;
  logic [6:0]                t10, low_key;
  logic [6:0]                rest_key;
  ntw_pkg::kind_t            kind_next;
  logic [ntw_pkg::KEY_W-1:0] key_next;
  logic                      last_next;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < ntw_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < ntw_pkg::GROUPS; k++) begin
      go[k] = bcd[12*k +: 4];
      gt[k] = bcd[12*k + 4 +: 4];
      gh[k] = bcd[12*k + 8 +: 4];
      grp_nz[k] = (bcd[12*k +: 12] != '0);
    end
  end

  assign h = gh[cmd.grp];
  assign t = gt[cmd.grp];
  assign o = go[cmd.grp];

  assign sts.grp_nz   = grp_nz;
  assign sts.h_nz     = (h != 4'd0);
  assign sts.rest_nz  = (t != 4'd0) || (o != 4'd0);
  assign sts.t_ge2    = (t >= 4'd2);
  assign sts.o_nz     = (o != 4'd0);
  assign sts.out_busy = out_valid && !out_ready;

  // below twenty the remainder is one word, otherwise the tens word alone
  assign t10      = {t, 3'b000} + {2'b00, t, 1'b0};
  assign low_key  = t10 + {3'b000, o};
  assign rest_key = (t < 4'd2) ? low_key : t10;

  always_comb begin
    kind_next = ntw_pkg::KIND_SPACE;
    key_next  = '0;
    last_next = 1'b0;
    unique case (cmd.step)
      ntw_pkg::STEP_SEP,
      ntw_pkg::STEP_SP1,
      ntw_pkg::STEP_SP2,
      ntw_pkg::STEP_SPS: kind_next = ntw_pkg::KIND_SPACE;
      ntw_pkg::STEP_HUND: begin
        kind_next = ntw_pkg::KIND_WORD;
        key_next  = {{(ntw_pkg::KEY_W-4){1'b0}}, h};
      end
      ntw_pkg::STEP_W100: begin
        kind_next = ntw_pkg::KIND_WORD;
        key_next  = ntw_pkg::KEY_W'(100);
      end
      ntw_pkg::STEP_TENS: begin
        kind_next = ntw_pkg::KIND_WORD;
        key_next  = {{(ntw_pkg::KEY_W-7){1'b0}}, rest_key};
      end
      ntw_pkg::STEP_HYPH: kind_next = ntw_pkg::KIND_HYPHEN;
      ntw_pkg::STEP_ONES: begin
        kind_next = ntw_pkg::KIND_WORD;
        key_next  = {{(ntw_pkg::KEY_W-4){1'b0}}, o};
      end
      ntw_pkg::STEP_SCALE: begin
        kind_next = ntw_pkg::KIND_WORD;
        key_next  = ntw_pkg::scale_key(cmd.grp);
      end
      ntw_pkg::STEP_ZERO: kind_next = ntw_pkg::KIND_WORD;
      ntw_pkg::STEP_NEWLINE: begin
        kind_next = ntw_pkg::KIND_NEWLINE;
        last_next = 1'b1;
      end
      default: kind_next = ntw_pkg::KIND_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= number;
      bcd <= '0;
    end else if (cmd.shift) begin
      {bcd, bin} <= {bcd_adj[ntw_pkg::BCD_W-2:0], bin, 1'b0};
    end
    if (cmd.emit) begin
      kind     <= kind_next;
      word_key <= key_next;
      last     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ntw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntw_ctrl - token sequencer
// Counts the conversion shifts, then walks the groups from the top down and
// steps through the tokens of each, one token per free output slot.
// ----------------------------------------------------------------------------
module ntw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ntw_pkg::sts_t sts,
  output ntw_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                  state, state_next;
  logic [ntw_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [ntw_pkg::GRP_W-1:0]   grp, grp_next;
  ntw_pkg::step_t              step, step_next;

  logic [ntw_pkg::GROUPS-1:0]  lower;
  logic [ntw_pkg::GRP_W-1:0]   top_grp, low_grp;
  ntw_pkg::step_t              after_rest;
  ntw_pkg::step_t              next_grp_step;
  logic [ntw_pkg::GRP_W-1:0]   next_grp;

  // highest nonzero group overall, and highest one below the current group
  always_comb begin
    top_grp = '0;
    low_grp = '0;
    for (int k = 0; k < ntw_pkg::GROUPS; k++) begin
      lower[k] = sts.grp_nz[k] && (ntw_pkg::GRP_W'(k) < grp);
      if (sts.grp_nz[k]) top_grp = ntw_pkg::GRP_W'(k);
      if (lower[k])      low_grp = ntw_pkg::GRP_W'(k);
    end
  end

  always_comb begin
    if (lower != '0) begin
      next_grp      = low_grp;
      next_grp_step = ntw_pkg::STEP_SEP;
    end else begin
      next_grp      = grp;
      next_grp_step = ntw_pkg::STEP_NEWLINE;
    end
    after_rest = (grp != '0) ? ntw_pkg::STEP_SPS : next_grp_step;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    grp_next   = grp;
    step_next  = step;
    in_ready   = (state == S_IDLE);
    cmd.load   = 1'b0;
    cmd.shift  = 1'b0;
    cmd.emit   = 1'b0;
    cmd.step   = step;
    cmd.grp    = grp;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == ntw_pkg::CONV_LAST) state_next = S_PICK;
      end
      S_PICK: begin
        if (sts.grp_nz == '0) begin
          step_next = ntw_pkg::STEP_ZERO;
        end else begin
          grp_next  = top_grp;
          step_next = ntw_pkg::STEP_HUND;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (step == ntw_pkg::STEP_HUND && !sts.h_nz) begin
          step_next = ntw_pkg::STEP_TENS;
        end else if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          unique case (step)
            ntw_pkg::STEP_SEP:  step_next = ntw_pkg::STEP_HUND;
            ntw_pkg::STEP_HUND: step_next = ntw_pkg::STEP_SP1;
            ntw_pkg::STEP_SP1:  step_next = ntw_pkg::STEP_W100;
            ntw_pkg::STEP_W100: step_next = sts.rest_nz ? ntw_pkg::STEP_SP2 : after_rest;
            ntw_pkg::STEP_SP2:  step_next = ntw_pkg::STEP_TENS;
            ntw_pkg::STEP_TENS: begin
              step_next = (sts.t_ge2 && sts.o_nz) ? ntw_pkg::STEP_HYPH : after_rest;
            end
            ntw_pkg::STEP_HYPH: step_next = ntw_pkg::STEP_ONES;
            ntw_pkg::STEP_ONES: step_next = after_rest;
            ntw_pkg::STEP_SPS:  step_next = ntw_pkg::STEP_SCALE;
            ntw_pkg::STEP_ZERO: step_next = ntw_pkg::STEP_NEWLINE;
            ntw_pkg::STEP_NEWLINE: state_next = S_IDLE;
            default:            step_next = ntw_pkg::STEP_NEWLINE;
          endcase
          if (step == ntw_pkg::STEP_SCALE ||
              ((step == ntw_pkg::STEP_W100 && !sts.rest_nz) ||
               (step == ntw_pkg::STEP_TENS && !(sts.t_ge2 && sts.o_nz)) ||
               step == ntw_pkg::STEP_ONES) && grp == '0) begin
            step_next = next_grp_step;
            grp_next  = next_grp;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      grp   <= '0;
      step  <= ntw_pkg::STEP_ZERO;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      grp   <= grp_next;
      step  <= step_next;
    end
  end

endmodule
